>>> design/ucd_pkg.sv
`default_nettype none

package ucd_pkg;

    localparam int unsigned PIPE_DEPTH = 9;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] valid;
    } pipe_ctl_t;

    // Each quotient below is floor(v * RECIP / 2**SHIFT), with RECIP rounded up.
    // SHIFT is the operand width plus the divisor's bit length, which makes it exact.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [9:0]  DAY_DIV      = 10'(SECS_PER_DAY >> 7);
    localparam int unsigned DAY_SHIFT    = 39;
    localparam logic [29:0] DAY_RECIP    =
        30'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

    // Days from 1600-03-01 to 1970-01-01.
    localparam logic [19:0] EPOCH_OFFSET = 20'd135080;
    localparam logic [19:0] EPOCH_WEEKDAY = 20'd3;

    localparam logic [17:0] ERA_DAYS  = 18'd146097;
    localparam int unsigned ERA_SHIFT = 38;
    localparam logic [20:0] ERA_RECIP =
        21'(((64'd1 << ERA_SHIFT) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam int unsigned HOUR_SHIFT    = 29;
    localparam logic [17:0] HOUR_RECIP    =
        18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

    localparam logic [2:0]  WEEK_DAYS  = 3'd7;
    localparam int unsigned WEEK_SHIFT = 23;
    localparam logic [20:0] WEEK_RECIP =
        21'(((64'd1 << WEEK_SHIFT) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    localparam logic [10:0] QUAD_DAYS  = 11'd1460;
    localparam int unsigned QUAD_SHIFT = 29;
    localparam logic [18:0] QUAD_RECIP =
        19'(((64'd1 << QUAD_SHIFT) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS));

    localparam logic [17:0] CENT_DAYS = 18'd36524;
    localparam logic [17:0] ERA_LAST  = 18'd146096;

    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam int unsigned YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_RECIP =
        19'(((64'd1 << YEAR_SHIFT) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam int unsigned MIN_SHIFT    = 18;
    localparam logic [12:0] MIN_RECIP    =
        13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    localparam logic [7:0]  MP_DIV   = 8'd153;
    localparam int unsigned MP_SHIFT = 19;
    localparam logic [11:0] MP_RECIP =
        12'(((64'd1 << MP_SHIFT) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

    localparam logic [8:0]  CENT_YEARS = 9'd100;
    localparam logic [12:0] BASE_YEAR  = 13'd1600;
    localparam logic [12:0] ERA_YEARS  = 13'd400;

    // Months counted from March: 0 is March, 10 is January, 11 is February.
    localparam logic [3:0] MP_JANUARY = 4'd10;
    localparam logic [3:0] MP_TO_JAN  = 4'd2;

    // First day of each March-based month within the March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> design/unix_seconds_to_calendar_date.sv
`default_nettype none

// Converts a count of seconds since 1970-01-01 00:00:00 UTC into the proleptic
// Gregorian date (year, zero-based month and day), the time of day and the weekday
// with Monday as 0. Every 36-bit input is valid; the top of the range falls in
// year 4147. The block is a nine-stage pipeline of constant divisions done as
// reciprocal multiplications, and one item can be accepted every cycle while
// the output is not stalled. A stall at the output holds the pipeline stage by
// stage, and empty stages keep accepting items. There are no registers to
// configure and no state between items.
module unix_seconds_to_calendar_date (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        epoch_valid,
    output logic             epoch_ready,
    input  wire logic [35:0] epoch_seconds,
    output logic             date_valid,
    input  wire logic        date_ready,
    output logic [12:0]      year,
    output logic [3:0]       month_index,
    output logic [4:0]       day_index,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [2:0]       weekday
);

    ucd_pkg::pipe_ctl_t pipe;

    ucd_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (epoch_valid),
        .in_ready  (epoch_ready),
        .out_valid (date_valid),
        .out_ready (date_ready),
        .ctl       (pipe)
    );

    // Stage 1: day number.
    logic [58:0] s1_prod;
    logic [35:0] s1_secs_reg;
    logic [19:0] s1_days_reg, s1_days_next;

    // Stage 2: time of day and day offsets.
    logic [29:0] s2_qmul;
    logic [28:0] s2_rem;
    logic [16:0] s2_tod_reg, s2_tod_next;
    logic [19:0] s2_z_reg, s2_z_next;
    logic [19:0] s2_wv_reg, s2_wv_next;

    // Stage 3: era, hour and week quotients.
    logic [40:0] s3_era_prod;
    logic [34:0] s3_hour_prod;
    logic [40:0] s3_wk_prod;
    logic [2:0]  s3_era_reg, s3_era_next;
    logic [19:0] s3_z_reg;
    logic [4:0]  s3_hour_reg, s3_hour_next;
    logic [16:0] s3_tod_reg;
    logic [16:0] s3_wkq_reg, s3_wkq_next;
    logic [19:0] s3_wv_reg;

    // Stage 4: day of era, seconds within the hour, weekday.
    logic [20:0] s4_era_mul;
    logic [19:0] s4_doe_diff;
    logic [16:0] s4_hour_mul;
    logic [16:0] s4_tod_diff;
    logic [19:0] s4_wk_mul;
    logic [19:0] s4_wk_diff;
    logic [2:0]  s4_era_reg;
    logic [17:0] s4_doe_reg, s4_doe_next;
    logic [4:0]  s4_hour_reg;
    logic [11:0] s4_tmin_reg, s4_tmin_next;
    logic [2:0]  s4_wday_reg, s4_wday_next;

    // Stage 5: leap-corrected day of era, minute.
    logic [36:0] s5_quad_prod;
    logic [6:0]  s5_quads;
    logic [2:0]  s5_cents;
    logic [24:0] s5_min_prod;
    logic [17:0] s5_t_reg, s5_t_next;
    logic [17:0] s5_doe_reg;
    logic [2:0]  s5_era_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_tmin_reg;
    logic [5:0]  s5_minute_reg, s5_minute_next;
    logic [2:0]  s5_wday_reg;

    // Stage 6: year of era, second.
    logic [36:0] s6_year_prod;
    logic [11:0] s6_min_mul;
    logic [11:0] s6_sec_diff;
    logic [8:0]  s6_yoe_reg, s6_yoe_next;
    logic [17:0] s6_doe_reg;
    logic [2:0]  s6_era_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_minute_reg;
    logic [5:0]  s6_second_reg, s6_second_next;
    logic [2:0]  s6_wday_reg;

    // Stage 7: day of year.
    logic [17:0] s7_year_mul;
    logic [1:0]  s7_cents;
    logic [17:0] s7_year_start;
    logic [17:0] s7_doy_diff;
    logic [8:0]  s7_doy_reg, s7_doy_next;
    logic [8:0]  s7_yoe_reg;
    logic [2:0]  s7_era_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_minute_reg;
    logic [5:0]  s7_second_reg;
    logic [2:0]  s7_wday_reg;

    // Stage 8: March-based month and base year.
    logic [10:0] s8_mp_arg;
    logic [22:0] s8_mp_prod;
    logic [3:0]  s8_mp_reg, s8_mp_next;
    logic [8:0]  s8_doy_reg;
    logic [12:0] s8_ybase_reg, s8_ybase_next;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_minute_reg;
    logic [5:0]  s8_second_reg;
    logic [2:0]  s8_wday_reg;

    // Stage 9: result.
    logic [8:0]  s9_day_diff;
    logic [12:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  weekday_reg;

    always_comb
    begin
        s1_prod      = 59'(epoch_seconds[35:7]) * 59'(ucd_pkg::DAY_RECIP);
        s1_days_next = s1_prod[ucd_pkg::DAY_SHIFT +: 20];

        s2_qmul     = 30'(s1_days_reg) * 30'(ucd_pkg::DAY_DIV);
        s2_rem      = s1_secs_reg[35:7] - s2_qmul[28:0];
        s2_tod_next = {s2_rem[9:0], s1_secs_reg[6:0]};
        s2_z_next   = s1_days_reg + ucd_pkg::EPOCH_OFFSET;
        s2_wv_next  = s1_days_reg + ucd_pkg::EPOCH_WEEKDAY;

        s3_era_prod  = 41'(s2_z_reg) * 41'(ucd_pkg::ERA_RECIP);
        s3_era_next  = s3_era_prod[ucd_pkg::ERA_SHIFT +: 3];
        s3_hour_prod = 35'(s2_tod_reg) * 35'(ucd_pkg::HOUR_RECIP);
        s3_hour_next = s3_hour_prod[ucd_pkg::HOUR_SHIFT +: 5];
        s3_wk_prod   = 41'(s2_wv_reg) * 41'(ucd_pkg::WEEK_RECIP);
        s3_wkq_next  = s3_wk_prod[ucd_pkg::WEEK_SHIFT +: 17];

        s4_era_mul   = 21'(s3_era_reg) * 21'(ucd_pkg::ERA_DAYS);
        s4_doe_diff  = s3_z_reg - s4_era_mul[19:0];
        s4_doe_next  = s4_doe_diff[17:0];
        s4_hour_mul  = 17'(s3_hour_reg) * 17'(ucd_pkg::SECS_PER_HOUR);
        s4_tod_diff  = s3_tod_reg - s4_hour_mul;
        s4_tmin_next = s4_tod_diff[11:0];
        s4_wk_mul    = 20'(s3_wkq_reg) * 20'(ucd_pkg::WEEK_DAYS);
        s4_wk_diff   = s3_wv_reg - s4_wk_mul;
        s4_wday_next = s4_wk_diff[2:0];

        s5_quad_prod = 37'(s4_doe_reg) * 37'(ucd_pkg::QUAD_RECIP);
        s5_quads     = s5_quad_prod[ucd_pkg::QUAD_SHIFT +: 7];
        s5_cents     = 3'(s4_doe_reg >= ucd_pkg::CENT_DAYS)
                     + 3'(s4_doe_reg >= 18'(2 * ucd_pkg::CENT_DAYS))
                     + 3'(s4_doe_reg >= 18'(3 * ucd_pkg::CENT_DAYS))
                     + 3'(s4_doe_reg >= 18'(4 * ucd_pkg::CENT_DAYS));
        s5_t_next    = s4_doe_reg - 18'(s5_quads) + 18'(s5_cents)
                     - 18'(s4_doe_reg >= ucd_pkg::ERA_LAST);
        s5_min_prod    = 25'(s4_tmin_reg) * 25'(ucd_pkg::MIN_RECIP);
        s5_minute_next = s5_min_prod[ucd_pkg::MIN_SHIFT +: 6];

        s6_year_prod   = 37'(s5_t_reg) * 37'(ucd_pkg::YEAR_RECIP);
        s6_yoe_next    = s6_year_prod[ucd_pkg::YEAR_SHIFT +: 9];
        s6_min_mul     = 12'(s5_minute_reg) * 12'(ucd_pkg::SECS_PER_MIN);
        s6_sec_diff    = s5_tmin_reg - s6_min_mul;
        s6_second_next = s6_sec_diff[5:0];

        s7_year_mul   = 18'(s6_yoe_reg) * 18'(ucd_pkg::YEAR_DAYS);
        s7_cents      = 2'(s6_yoe_reg >= ucd_pkg::CENT_YEARS)
                      + 2'(s6_yoe_reg >= 9'(2 * ucd_pkg::CENT_YEARS))
                      + 2'(s6_yoe_reg >= 9'(3 * ucd_pkg::CENT_YEARS));
        s7_year_start = s7_year_mul + 18'(s6_yoe_reg[8:2]) - 18'(s7_cents);
        s7_doy_diff   = s6_doe_reg - s7_year_start;
        s7_doy_next   = s7_doy_diff[8:0];

        s8_mp_arg     = 11'(s7_doy_reg) * 11'd5 + 11'd2;
        s8_mp_prod    = 23'(s8_mp_arg) * 23'(ucd_pkg::MP_RECIP);
        s8_mp_next    = s8_mp_prod[ucd_pkg::MP_SHIFT +: 4];
        s8_ybase_next = ucd_pkg::BASE_YEAR + 13'(s7_era_reg) * ucd_pkg::ERA_YEARS
                      + 13'(s7_yoe_reg);

        s9_day_diff = s8_doy_reg - ucd_pkg::month_start(s8_mp_reg);
        day_next    = s9_day_diff[4:0];
        if (s8_mp_reg >= ucd_pkg::MP_JANUARY)
        begin
            month_next = s8_mp_reg - ucd_pkg::MP_JANUARY;
            year_next  = s8_ybase_reg + 13'd1;
        end
        else
        begin
            month_next = s8_mp_reg + ucd_pkg::MP_TO_JAN;
            year_next  = s8_ybase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            s1_secs_reg <= epoch_seconds;
            s1_days_reg <= s1_days_next;
        end
        if (pipe.load[1])
        begin
            s2_tod_reg <= s2_tod_next;
            s2_z_reg   <= s2_z_next;
            s2_wv_reg  <= s2_wv_next;
        end
        if (pipe.load[2])
        begin
            s3_era_reg  <= s3_era_next;
            s3_z_reg    <= s2_z_reg;
            s3_hour_reg <= s3_hour_next;
            s3_tod_reg  <= s2_tod_reg;
            s3_wkq_reg  <= s3_wkq_next;
            s3_wv_reg   <= s2_wv_reg;
        end
        if (pipe.load[3])
        begin
            s4_era_reg  <= s3_era_reg;
            s4_doe_reg  <= s4_doe_next;
            s4_hour_reg <= s3_hour_reg;
            s4_tmin_reg <= s4_tmin_next;
            s4_wday_reg <= s4_wday_next;
        end
        if (pipe.load[4])
        begin
            s5_t_reg      <= s5_t_next;
            s5_doe_reg    <= s4_doe_reg;
            s5_era_reg    <= s4_era_reg;
            s5_hour_reg   <= s4_hour_reg;
            s5_tmin_reg   <= s4_tmin_reg;
            s5_minute_reg <= s5_minute_next;
            s5_wday_reg   <= s4_wday_reg;
        end
        if (pipe.load[5])
        begin
            s6_yoe_reg    <= s6_yoe_next;
            s6_doe_reg    <= s5_doe_reg;
            s6_era_reg    <= s5_era_reg;
            s6_hour_reg   <= s5_hour_reg;
            s6_minute_reg <= s5_minute_reg;
            s6_second_reg <= s6_second_next;
            s6_wday_reg   <= s5_wday_reg;
        end
        if (pipe.load[6])
        begin
            s7_doy_reg    <= s7_doy_next;
            s7_yoe_reg    <= s6_yoe_reg;
            s7_era_reg    <= s6_era_reg;
            s7_hour_reg   <= s6_hour_reg;
            s7_minute_reg <= s6_minute_reg;
            s7_second_reg <= s6_second_reg;
            s7_wday_reg   <= s6_wday_reg;
        end
        if (pipe.load[7])
        begin
            s8_mp_reg     <= s8_mp_next;
            s8_doy_reg    <= s7_doy_reg;
            s8_ybase_reg  <= s8_ybase_next;
            s8_hour_reg   <= s7_hour_reg;
            s8_minute_reg <= s7_minute_reg;
            s8_second_reg <= s7_second_reg;
            s8_wday_reg   <= s7_wday_reg;
        end
        if (pipe.load[8])
        begin
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= s8_hour_reg;
            minute_reg  <= s8_minute_reg;
            second_reg  <= s8_second_reg;
            weekday_reg <= s8_wday_reg;
        end
    end

    assign year        = year_reg;
    assign month_index = month_reg;
    assign day_index   = day_reg;
    assign hour        = hour_reg;
    assign minute      = minute_reg;
    assign second      = second_reg;
    assign weekday     = weekday_reg;

`ifndef SYNTH
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (year >= 13'd1970 && month_index <= 4'd11 && day_index <= 5'd30
                        && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
                        && weekday <= 3'd6))
        else $error("result item field out of range");
`endif

endmodule

`default_nettype wire

>>> design/ucd_pipe_ctl.sv
`default_nettype none

module ucd_pipe_ctl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ucd_pkg::pipe_ctl_t    ctl
);

    localparam int unsigned LAST = ucd_pkg::PIPE_DEPTH - 1;

    logic [ucd_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [ucd_pkg::PIPE_DEPTH-1:0] valid_next;
    logic [ucd_pkg::PIPE_DEPTH-1:0] load;

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i <= LAST; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[LAST];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

`ifndef SYNTH
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            $countones(valid_reg) + int'($past(out_valid && out_ready))
            == $past($countones(valid_reg)) + int'($past(in_valid && in_ready)))
        else $error("item count in pipeline does not match accepted items");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg == '0 |-> in_ready)
        else $error("empty pipeline refuses an item");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("full stalled pipeline takes an item");
`endif

endmodule

`default_nettype wire

>>> bench/unix_seconds_to_calendar_date_tb.sv
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_tb;

    localparam longint unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned     SECS_PER_HOUR = 3600;
    localparam int unsigned     SECS_PER_MIN  = 60;
    localparam int unsigned     EPOCH_YEAR    = 1970;
    localparam int unsigned     EPOCH_WEEKDAY = 3;
    localparam int unsigned     ERA_DAYS      = 146097;
    localparam int unsigned     ERA_YEARS     = 400;
    localparam int unsigned     LAST_DAY      = 795363;
    localparam int unsigned     RANDOM_ITEMS  = 1200;
    localparam int unsigned     DRAIN_CYCLES  = 20;
    localparam int unsigned     MONTH_DAYS [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month_index;
        logic [4:0]  day_index;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    typedef struct packed {
        logic [35:0] secs;
        logic        typed;
        calendar_t   want;
    } directed_row_t;

    localparam int unsigned DIRECTED_ROWS = 17;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{36'd0,           1'b1, '{13'd1970, 4'd0, 5'd0,  5'd0,  6'd0,  6'd0,  3'd3}},
        '{36'd59,          1'b0, '0},
        '{36'd3599,        1'b0, '0},
        '{36'd86399,       1'b1, '{13'd1970, 4'd0, 5'd0,  5'd23, 6'd59, 6'd59, 3'd3}},
        '{36'd86400,       1'b1, '{13'd1970, 4'd0, 5'd1,  5'd0,  6'd0,  6'd0,  3'd4}},
        '{36'd68169600,    1'b0, '0},
        '{36'd94694399,    1'b0, '0},
        '{36'd951782400,   1'b0, '0},
        '{36'd4107456000,  1'b0, '0},
        '{36'd4107542400,  1'b0, '0},
        '{36'd4294967296,  1'b0, '0},
        '{36'd13574563200, 1'b0, '0},
        '{36'h555555555,   1'b0, '0},
        '{36'hAAAAAAAAA,   1'b0, '0},
        '{36'h7FFFFFFFF,   1'b0, '0},
        '{36'h800000000,   1'b0, '0},
        '{36'hFFFFFFFFF,   1'b1, '{13'd4147, 4'd7, 5'd19, 5'd7,  6'd32, 6'd15, 3'd6}}
    };

    logic        clk;
    logic        rst_n;
    logic        epoch_valid;
    logic        epoch_ready;
    logic [35:0] epoch_seconds;
    logic        date_valid;
    logic        date_ready;
    logic [12:0] year;
    logic [3:0]  month_index;
    logic [4:0]  day_index;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    calendar_t expected_dates [$];
    int unsigned mismatches = 0;

    unix_seconds_to_calendar_date dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_valid   (epoch_valid),
        .epoch_ready   (epoch_ready),
        .epoch_seconds (epoch_seconds),
        .date_valid    (date_valid),
        .date_ready    (date_ready),
        .year          (year),
        .month_index   (month_index),
        .day_index     (day_index),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic calendar_t calendar_of(input logic [35:0] secs);
        calendar_t       c;
        longint unsigned days;
        longint unsigned rem;
        int unsigned     tod;
        int unsigned     yr;
        int unsigned     ylen;
        int unsigned     mon;
        int unsigned     mlen;
        days = 64'(secs) / SECS_PER_DAY;
        tod = 32'(64'(secs) % SECS_PER_DAY);
        rem = days;
        yr = EPOCH_YEAR;
        while (rem >= ERA_DAYS)
        begin
            rem -= ERA_DAYS;
            yr += ERA_YEARS;
        end
        ylen = is_leap(yr) ? 366 : 365;
        while (rem >= ylen)
        begin
            rem -= ylen;
            yr++;
            ylen = is_leap(yr) ? 366 : 365;
        end
        mon = 0;
        mlen = MONTH_DAYS[0];
        while (mon < 11 && rem >= mlen)
        begin
            rem -= mlen;
            mon++;
            mlen = MONTH_DAYS[mon] + ((mon == 1 && is_leap(yr)) ? 1 : 0);
        end
        c.year        = 13'(yr);
        c.month_index = 4'(mon);
        c.day_index   = 5'(rem);
        c.hour        = 5'(tod / SECS_PER_HOUR);
        c.minute      = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
        c.second      = 6'(tod % SECS_PER_MIN);
        c.weekday     = 3'((days + EPOCH_WEEKDAY) % 7);
        return c;
    endfunction

    function automatic int unsigned idle_cycles(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [35:0] random_seconds();
        int unsigned mode;
        int unsigned tod;
        mode = $urandom_range(0, 3);
        case (mode)
            0: return {4'($urandom_range(0, 15)), 32'($urandom())};
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       tod = 0;
                    1:       tod = 32'(SECS_PER_DAY) - 1;
                    default: tod = $urandom_range(0, 32'(SECS_PER_DAY) - 1);
                endcase
                return 36'(64'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY + 64'(tod));
            end
            2: return 36'($urandom_range(0, 32'hFFFFF));
            default: return 36'hFFFFFFFFF - 36'($urandom_range(0, 32'hFFFFFF));
        endcase
    endfunction

    task automatic send_seconds(input logic [35:0] secs, input calendar_t want,
                                input bit steady);
        int unsigned gap;
        gap = idle_cycles(steady);
        if (gap > 0)
        begin
            epoch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        epoch_valid   <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (!epoch_ready)
            @(posedge clk);
        expected_dates.push_back(want);
    endtask

    task automatic compare_field(input string name, input logic [12:0] want,
                                 input logic [12:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_date();
        calendar_t want;
        if (expected_dates.size() == 0)
        begin
            $display("%0t: date item with none expected, actual %0d-%0d-%0d", $time,
                     year, month_index, day_index);
            mismatches++;
            return;
        end
        want = expected_dates.pop_front();
        compare_field("year", want.year, year);
        compare_field("month_index", 13'(want.month_index), 13'(month_index));
        compare_field("day_index", 13'(want.day_index), 13'(day_index));
        compare_field("hour", 13'(want.hour), 13'(hour));
        compare_field("minute", 13'(want.minute), 13'(minute));
        compare_field("second", 13'(want.second), 13'(second));
        compare_field("weekday", 13'(want.weekday), 13'(weekday));
    endtask

    initial
    begin
        int unsigned hold;
        int unsigned taken;
        hold = 0;
        taken = 0;
        date_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && date_valid && date_ready)
            begin
                check_date();
                taken++;
                hold = idle_cycles((taken / 64) % 3 == 1);
            end
            if (hold > 0)
            begin
                date_ready <= 1'b0;
                hold--;
            end
            else
            begin
                date_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [35:0] secs;
        rst_n         <= 1'b0;
        epoch_valid   <= 1'b0;
        epoch_seconds <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            secs = directed_rows[i].secs;
            send_seconds(secs, directed_rows[i].typed ? directed_rows[i].want
                                                      : calendar_of(secs), 1'b0);
        end

        epoch_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                epoch_valid <= 1'b0;
                while (expected_dates.size() != 0)
                    @(posedge clk);
            end
            secs = random_seconds();
            send_seconds(secs, calendar_of(secs), (n / 100) % 3 == 2);
        end
        epoch_valid <= 1'b0;

        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
design/ucd_pkg.sv
design/ucd_pipe_ctl.sv
design/unix_seconds_to_calendar_date.sv
bench/unix_seconds_to_calendar_date_tb.sv
